@@ sv/ps2mct_pkg.sv @@
// Package for the PS/2 mouse packet cursor tracker.
// Holds the shared types, byte codes, register indexes and reset values.
// No dependencies.
package ps2mct_pkg;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;
  localparam int unsigned POS_W  = 12;

  localparam logic [7:0] ACK_BYTE  = 8'hFA;
  localparam logic [7:0] HDR_MASK  = 8'hC8;
  localparam logic [7:0] HDR_MATCH = 8'h08;

  localparam logic [POS_W-1:0] START_POS  = 12'd100;
  localparam logic [POS_W-1:0] MAXX_RESET = 12'(320 - 16);
  localparam logic [POS_W-1:0] MAXY_RESET = 12'(200 - 16);

  // Register index, taken from paddr[2]
  localparam logic REG_MAX_X = 1'b0;
  localparam logic REG_MAX_Y = 1'b1;

  typedef enum logic [3:0] {
    PH_WAIT_ACK = 4'b0001,
    PH_HDR      = 4'b0010,
    PH_X        = 4'b0100,
    PH_Y        = 4'b1000
  } phase_t;

  typedef struct packed {
    logic              emit;
    logic [2:0]        buttons;
    logic signed [8:0] dx;
    logic signed [9:0] dy;
  } pkt_t;

endpackage

@@ sv/ps2mct_framer.sv @@
// Packet framer: waits for acknowledge, frames header/X/Y bytes, decodes deltas.
// Depends on ps2mct_pkg.
module ps2mct_framer (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        byte_in,
  output ps2mct_pkg::pkt_t  pkt
);
  import ps2mct_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] header_byte;
  logic [7:0] x_byte;
  logic       hdr_ok;
  logic [9:0] y_ext;

  assign hdr_ok = (byte_in & HDR_MASK) == HDR_MATCH;

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_WAIT_ACK: if (byte_in == ACK_BYTE) phase_next = PH_HDR;
      PH_HDR:      if (hdr_ok) phase_next = PH_X;
      PH_X:        phase_next = PH_Y;
      PH_Y:        phase_next = PH_HDR;
      default:     phase_next = PH_WAIT_ACK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_WAIT_ACK;
      header_byte <= '0;
      x_byte      <= '0;
    end else if (fire) begin
      phase <= phase_next;
      if (phase == PH_HDR && hdr_ok) header_byte <= byte_in;
      if (phase == PH_X) x_byte <= byte_in;
    end
  end

  // Sign-extend Y with header bit 5, then negate so positive is downward
  assign y_ext       = {header_byte[5], header_byte[5], byte_in};
  assign pkt.emit    = (phase == PH_Y);
  assign pkt.buttons = header_byte[2:0];
  assign pkt.dx      = $signed({header_byte[4], x_byte});
  assign pkt.dy      = $signed(10'd0 - y_ext);

  a_y_returns_hdr: assert property (@(posedge clk) disable iff (rst)
    (fire && phase == PH_Y) |=> phase == PH_HDR)
    else $error("framer did not return to header after Y byte");

  a_wait_needs_ack: assert property (@(posedge clk) disable iff (rst)
    (fire && phase == PH_WAIT_ACK && byte_in != ACK_BYTE) |=> phase == PH_WAIT_ACK)
    else $error("framer left acknowledge wait without acknowledge byte");

  a_bad_hdr_dropped: assert property (@(posedge clk) disable iff (rst)
    (fire && phase == PH_HDR && !hdr_ok) |=> phase == PH_HDR && $stable(header_byte))
    else $error("bad header byte was taken");

endmodule

@@ sv/ps2mct_cursor.sv @@
// Cursor position keeper: adds packet deltas and clamps each axis to 0..max.
// Depends on ps2mct_pkg.
module ps2mct_cursor (
  input  logic              clk,
  input  logic              rst,
  input  logic              upd,
  input  logic signed [8:0] dx,
  input  logic signed [9:0] dy,
  input  logic [11:0]       max_x,
  input  logic [11:0]       max_y,
  output logic [11:0]       pos_x_next,
  output logic [11:0]       pos_y_next
);
  import ps2mct_pkg::*;

  logic [11:0] pos_x, pos_y;

  // Raise to zero first, then lower to the limit
  function automatic logic [11:0] move_clamp(input logic [11:0] pos,
                                             input logic signed [9:0] d,
                                             input logic [11:0] lim);
    logic signed [13:0] sum;
    logic [11:0]        res;
    sum = $signed({2'b00, pos}) + 14'(d);
    if (sum < 0)
      res = '0;
    else if (sum > $signed({2'b00, lim}))
      res = lim;
    else
      res = sum[11:0];
    return res;
  endfunction

  assign pos_x_next = move_clamp(pos_x, 10'(dx), max_x);
  assign pos_y_next = move_clamp(pos_y, dy, max_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= START_POS;
      pos_y <= START_POS;
    end else if (upd) begin
      pos_x <= pos_x_next;
      pos_y <= pos_y_next;
    end
  end

  a_x_in_range: assert property (@(posedge clk) disable iff (rst)
    upd |=> pos_x <= $past(max_x))
    else $error("cursor x above its limit after update");

  a_y_in_range: assert property (@(posedge clk) disable iff (rst)
    upd |=> pos_y <= $past(max_y))
    else $error("cursor y above its limit after update");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !upd |=> $stable(pos_x) && $stable(pos_y))
    else $error("cursor moved without a packet");

endmodule

@@ sv/ps2_mouse_packet_cursor_tracker.sv @@
// Top level of the PS/2 mouse packet cursor tracker.
// Depends on ps2mct_pkg, ps2mct_framer and ps2mct_cursor.
//
//  channel  direction  handshake          payload
//  in       sink       in_valid/in_stall  mouse_byte
//  out      source     out_valid/out_stall buttons, delta_x, delta_y, cursor_x, cursor_y
//  cfg      APB slave  psel/penable/pready max_cursor_x @0, max_cursor_y @4
//
// One byte per cycle sustained, unless a Y byte waits for a stalled output; a
// completed packet passes from the input register, where its Y byte is accepted,
// to the result register, from which it can be taken.
// The input register and the result register part the two sides, so a byte is
// taken while a result waits; bytes that make no result proceed even when the
// output is stalled, and only a Y byte waits for a free result register.
// Synchronous reset: framing waits for acknowledge, cursor at 100/100, limits
// 304 and 184, both registers empty.
module ps2_mouse_packet_cursor_tracker (
  input  logic                            clk,
  input  logic                            rst,
  // byte input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      mouse_byte,
  // result output
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      buttons,
  output logic signed [8:0]               delta_x,
  output logic signed [9:0]               delta_y,
  output logic [11:0]                     cursor_x,
  output logic [11:0]                     cursor_y,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ps2mct_pkg::CFG_AW-1:0]   paddr,
  input  logic [ps2mct_pkg::CFG_DW-1:0]   pwdata,
  output logic [ps2mct_pkg::CFG_DW-1:0]   prdata,
  output logic                            pready
);
  import ps2mct_pkg::*;

  logic        in_reg_valid;
  logic [7:0]  in_reg_byte;
  logic        out_free;
  logic        fire;
  logic        cfg_wr;
  logic [11:0] max_cursor_x;
  logic [11:0] max_cursor_y;
  logic [11:0] pos_x_next, pos_y_next;
  pkt_t        pkt;

  // Configuration port: always ready, index from paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_cursor_x <= MAXX_RESET;
      max_cursor_y <= MAXY_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_MAX_X: max_cursor_x <= pwdata[11:0];
        REG_MAX_Y: max_cursor_y <= pwdata[11:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MAX_X: prdata = {20'd0, max_cursor_x};
      REG_MAX_Y: prdata = {20'd0, max_cursor_y};
      default:   prdata = '0;
    endcase
  end

  // Result register is free when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;
  // Process the held byte unless it completes a packet and the output is full
  assign fire     = in_reg_valid && (!pkt.emit || out_free);
  assign in_stall = in_reg_valid && !fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_reg_byte <= mouse_byte;
  end

  ps2mct_framer u_framer (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .byte_in (in_reg_byte),
    .pkt     (pkt)
  );

  ps2mct_cursor u_cursor (
    .clk        (clk),
    .rst        (rst),
    .upd        (fire && pkt.emit),
    .dx         (pkt.dx),
    .dy         (pkt.dy),
    .max_x      (max_cursor_x),
    .max_y      (max_cursor_y),
    .pos_x_next (pos_x_next),
    .pos_y_next (pos_y_next)
  );

  // Result register: hold while stalled, load on a completed packet
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fire && pkt.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && pkt.emit) begin
      buttons  <= pkt.buttons;
      delta_x  <= pkt.dx;
      delta_y  <= pkt.dy;
      cursor_x <= pos_x_next;
      cursor_y <= pos_y_next;
    end
  end

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_reg_valid && pkt.emit && !out_free)
    else $error("input stalled without a blocked packet");

  a_result_from_packet: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(fire && pkt.emit))
    else $error("result appeared without a completed packet");

  a_cursor_limit: assert property (@(posedge clk) disable iff (rst)
    (fire && pkt.emit) |=> out_valid && cursor_x <= $past(max_cursor_x)
                           && cursor_y <= $past(max_cursor_y))
    else $error("result cursor outside its limits");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for ps2_mouse_packet_cursor_tracker: byte framing, deltas and cursor clamp.
// Depends on ps2mct_pkg and the tracker RTL; drives bytes, APB writes and random back-pressure.
module tb_top;
  import ps2mct_pkg::*;

  // Header bit positions that carry the delta signs, and the button field
  localparam int         X_SIGN_BIT   = 4;
  localparam int         Y_SIGN_BIT   = 5;
  localparam logic [7:0] BUTTON_MASK  = 8'h07;
  // Bits a well-formed header may carry freely (everything outside HDR_MASK)
  localparam logic [7:0] HDR_FREE     = 8'h37;
  localparam int         RANDOM_BYTES = 1250;
  localparam int         N_SETTINGS   = 10;
  localparam int         N_DIRECTED   = 25;

  typedef struct packed {
    logic [2:0]        buttons;
    logic signed [8:0] dx;
    logic signed [9:0] dy;
    logic [11:0]       cx;
    logic [11:0]       cy;
  } move_t;

  typedef struct packed {
    logic [7:0] b;
    logic       pinned;
    move_t      want;
  } byte_row_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [7:0]          mouse_byte;
  logic                out_valid;
  logic                out_stall;
  logic [2:0]          buttons;
  logic signed [8:0]   delta_x;
  logic signed [9:0]   delta_y;
  logic [11:0]         cursor_x;
  logic [11:0]         cursor_y;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [CFG_DW-1:0]   pwdata;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  // Shadow of the tracker: framing phase, captured bytes, cursor and limits
  phase_t      trk_phase;
  logic [7:0]  trk_hdr;
  logic [7:0]  trk_xbyte;
  logic [11:0] trk_px;
  logic [11:0] trk_py;
  logic [11:0] lim_x;
  logic [11:0] lim_y;

  move_t       predicted_moves [$];
  move_t       pinned_moves [$];
  byte_row_t   byte_rows [N_DIRECTED];
  int          mismatches = 0;
  bit          calm = 1'b0;
  int          hold_len = 0;

  ps2_mouse_packet_cursor_tracker uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mouse_byte (mouse_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .buttons    (buttons),
    .delta_x    (delta_x),
    .delta_y    (delta_y),
    .cursor_x   (cursor_x),
    .cursor_y   (cursor_y),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Raise to zero first, then lower to the limit; the kept position may sit above
  // a limit that was lowered since the last packet.
  function automatic int clamp_axis(int pos, int delta, int lim);
    int s;
    s = pos + delta;
    if (s < 0) s = 0;
    if (s > lim) s = lim;
    return s;
  endfunction

  // Advance the shadow by one accepted byte; queue a move when a packet closes.
  function automatic void track_byte(logic [7:0] b);
    int    dx;
    int    dy;
    move_t m;
    case (trk_phase)
      PH_WAIT_ACK: begin
        if (b == ACK_BYTE) trk_phase = PH_HDR;
      end
      PH_HDR: begin
        // drop anything that fails the header test to resynchronize
        if ((b & HDR_MASK) == HDR_MATCH) begin
          trk_hdr   = b;
          trk_phase = PH_X;
        end
      end
      PH_X: begin
        trk_xbyte = b;
        trk_phase = PH_Y;
      end
      default: begin
        trk_phase = PH_HDR;
        dx = trk_hdr[X_SIGN_BIT] ? int'(trk_xbyte) - 256 : int'(trk_xbyte);
        // negate Y so that positive means downward
        dy = trk_hdr[Y_SIGN_BIT] ? 256 - int'(b) : -int'(b);
        trk_px = 12'(clamp_axis(int'(trk_px), dx, int'(lim_x)));
        trk_py = 12'(clamp_axis(int'(trk_py), dy, int'(lim_y)));
        m.buttons = 3'(trk_hdr & BUTTON_MASK);
        m.dx      = 9'(dx);
        m.dy      = 10'(dy);
        m.cx      = trk_px;
        m.cy      = trk_py;
        // a hand-typed expectation, when one is waiting, stands in for the prediction
        if (pinned_moves.size() > 0) predicted_moves.push_back(pinned_moves.pop_front());
        else predicted_moves.push_back(m);
      end
    endcase
  endfunction

  // Input side: every accepted byte goes through the shadow.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) track_byte(mouse_byte);
  end

  // Output side: compare each accepted move transaction with the oldest prediction.
  always @(posedge clk) begin
    move_t got;
    move_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{buttons, delta_x, delta_y, cursor_x, cursor_y};
      if (predicted_moves.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: move with none expected: btn=%0d dx=%0d dy=%0d x=%0d y=%0d",
                   $realtime, got.buttons, got.dx, got.dy, got.cx, got.cy);
      end else begin
        want = predicted_moves.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: move differs: exp btn=%0d dx=%0d dy=%0d x=%0d y=%0d",
                      " got btn=%0d dx=%0d dy=%0d x=%0d y=%0d"}, $realtime,
                     want.buttons, want.dx, want.dy, want.cx, want.cy,
                     got.buttons, got.dx, got.dy, got.cx, got.cy);
        end
      end
    end
  end

  // Receiver: random stall runs, mostly short with a few long ones; calm stretches
  // take none, and a requested hold-off is counted down here.
  initial begin
    int run;
    int r;
    run       = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_stall = 1'b1;
        hold_len--;
      end else if (calm) begin
        out_stall = 1'b0;
      end else if (run > 0) begin
        run--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_stall = 1'b0;
          run       = $urandom_range(0, 6);
        end else if (r < 95) begin
          out_stall = 1'b1;
          run       = $urandom_range(0, 3);
        end else begin
          out_stall = 1'b1;
          run       = $urandom_range(10, 40);
        end
      end
    end
  end

  // Offer one byte after a random gap and hold it until taken. Called at a falling edge.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    mouse_byte = b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted move has come, plus the pipeline depth.
  task automatic wait_drained;
    in_valid = 1'b0;
    while (predicted_moves.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_write(input logic idx, input logic [11:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = CFG_DW'(val);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_MAX_X) lim_x = val;
    else lim_y = val;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  initial begin
    int         sent;
    int         r;
    int         drift;
    logic [7:0] hdr;
    logic [7:0] xb;
    logic [7:0] yb;

    rst        = 1'b1;
    in_valid   = 1'b0;
    mouse_byte = 8'h00;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    trk_phase  = PH_WAIT_ACK;
    trk_hdr    = 8'h00;
    trk_xbyte  = 8'h00;
    trk_px     = START_POS;
    trk_py     = START_POS;
    lim_x      = MAXX_RESET;
    lim_y      = MAXY_RESET;

    // Directed bytes with reset limits (304/184) and the cursor starting at 100/100.
    // Typed moves are read straight off the packet bytes.
    byte_rows = '{
      '{8'h08, 1'b0, '0},  // header-looking byte before acknowledge: ignore
      '{8'h00, 1'b0, '0},  // ignore
      '{8'hFA, 1'b0, '0},  // acknowledge, start framing
      '{8'hC8, 1'b0, '0},  // bad header: drop
      '{8'hFF, 1'b0, '0},  // bad header: drop
      '{8'h0F, 1'b0, '0},  // all buttons, no signs
      '{8'h7F, 1'b0, '0},
      '{8'h80, 1'b1, '{3'd7, 9'sd127, -10'sd128, 12'd227, 12'd0}},
      '{8'h38, 1'b0, '0},  // both signs: most negative X, most positive downward Y
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b1, '{3'd0, 9'h100, 10'sd256, 12'd0, 12'd184}},
      '{8'h09, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'hFA, 1'b1, '{3'd1, 9'sd255, -10'sd250, 12'd255, 12'd0}},  // ack value as Y byte
      '{8'h3A, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'h01, 1'b1, '{3'd2, -9'sd1, 10'sd255, 12'd254, 12'd184}},
      '{8'h0C, 1'b0, '0},
      '{8'h80, 1'b0, '0},
      '{8'hFF, 1'b1, '{3'd4, 9'sd128, -10'sd255, 12'd304, 12'd0}},
      '{8'hFA, 1'b0, '0},  // ack value offered as header: drop
      '{8'h48, 1'b0, '0},  // bit 6 set: drop
      '{8'h08, 1'b0, '0},
      '{8'h01, 1'b0, '0},
      '{8'h01, 1'b0, '0}
    };

    repeat (8) @(negedge clk);
    rst = 1'b0;

    foreach (byte_rows[i]) begin
      if (byte_rows[i].pinned) pinned_moves.push_back(byte_rows[i].want);
      send_byte(byte_rows[i].b);
    end

    // Random part: one limit setting per stretch, written only while idle.
    for (int s = 0; s < N_SETTINGS; s++) begin
      wait_drained;
      drift = $urandom_range(0, 2);
      case (s)
        0: begin
          // drive toward the top of the widest range
          apb_write(REG_MAX_X, 12'd4095);
          apb_write(REG_MAX_Y, 12'd4095);
          drift = 1;
        end
        1: begin
          apb_write(REG_MAX_X, 12'd0);
          apb_write(REG_MAX_Y, 12'd0);
        end
        2: begin
          // small limits after the zero limits
          apb_write(REG_MAX_X, 12'd50);
          apb_write(REG_MAX_Y, 12'd20);
        end
        3: begin
          apb_write(REG_MAX_X, MAXX_RESET);
          apb_write(REG_MAX_Y, MAXY_RESET);
        end
        default: begin
          if ($urandom_range(0, 1) == 0) begin
            apb_write(REG_MAX_X, 12'($urandom_range(0, 120)));
            apb_write(REG_MAX_Y, 12'($urandom_range(0, 120)));
          end else begin
            apb_write(REG_MAX_X, 12'($urandom_range(0, 4095)));
            apb_write(REG_MAX_Y, 12'($urandom_range(0, 4095)));
          end
        end
      endcase
      calm = (s == 3);
      // long receiver hold-off while bytes keep coming, so the input backs up
      if (s == 5) hold_len = 400;

      sent = 0;
      while (sent < RANDOM_BYTES / N_SETTINGS) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          // well-formed packet with random content, biased when drifting
          hdr = (8'($urandom) & HDR_FREE) | HDR_MATCH;
          xb  = 8'($urandom);
          yb  = 8'($urandom);
          if (drift != 0 && $urandom_range(0, 9) < 7) begin
            if (drift == 1) begin
              hdr[X_SIGN_BIT] = 1'b0;
              hdr[Y_SIGN_BIT] = 1'b1;
              xb = 8'($urandom_range(128, 255));
              yb = 8'($urandom_range(0, 127));
            end else begin
              hdr[X_SIGN_BIT] = 1'b1;
              hdr[Y_SIGN_BIT] = 1'b0;
              xb = 8'($urandom_range(0, 127));
              yb = 8'($urandom_range(128, 255));
            end
          end
          send_byte(hdr);
          send_byte(xb);
          send_byte(yb);
          sent += 3;
        end else if (r < 95) begin
          // stray byte: may break framing or start a packet
          send_byte(8'($urandom));
          sent++;
        end else begin
          send_byte(ACK_BYTE);
          sent++;
        end
      end
      calm = 1'b0;
    end

    wait_drained;
    repeat (8) @(negedge clk);
    if (mismatches == 0 && predicted_moves.size() == 0) begin
      $display("ps2_mouse_packet_cursor_tracker: match");
    end else begin
      $display("ps2_mouse_packet_cursor_tracker: mismatch");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(20_000_000);
    $display("ps2_mouse_packet_cursor_tracker: mismatch");
    $finish;
  end

endmodule
